### rtl/imk_pkg.sv
// imk_pkg: shared constants and types of the iambic morse keyer
// phase codes, element codes, register reset value and the result payload type
// no dependencies
package imk_pkg;

   localparam int TIMER_BITS_DEFAULT = 12;

   localparam int DIT_W  = 11;
   localparam int ELEM_W = 2;
   localparam int PH_W   = 3;
   // dit length times three fits in this many bits
   localparam int MARK3_W = DIT_W + 2;

   localparam logic [DIT_W-1:0] DIT_TICKS_RESET = DIT_W'(60);

   localparam logic [PH_W-1:0] PH_IDLE      = 3'd0;
   localparam logic [PH_W-1:0] PH_DIT_MARK  = 3'd1;
   localparam logic [PH_W-1:0] PH_DIT_SPACE = 3'd2;
   localparam logic [PH_W-1:0] PH_DAH_MARK  = 3'd3;
   localparam logic [PH_W-1:0] PH_DAH_SPACE = 3'd4;

   localparam logic [ELEM_W-1:0] ELEM_IDLE = 2'd0;
   localparam logic [ELEM_W-1:0] ELEM_DIT  = 2'd1;
   localparam logic [ELEM_W-1:0] ELEM_DAH  = 2'd2;

   typedef struct packed {
      logic              tone;
      logic [ELEM_W-1:0] element;
   } rsp_type;

endpackage

### rtl/imk_if.sv
// imk_req_if / imk_rsp_if: valid-ready channels of the keyer
// paddle levels in, tone and element out
// depends on imk_pkg
interface imk_req_if;
   logic valid;
   logic ready;
   logic dah_paddle;
   logic dit_paddle;

   modport source (output valid, output dah_paddle, output dit_paddle, input ready);
   modport sink   (input valid, input dah_paddle, input dit_paddle, output ready);
endinterface

interface imk_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          tone;
   logic [imk_pkg::ELEM_W-1:0]    element;

   modport source (output valid, output tone, output element, input ready);
   modport sink   (input valid, input tone, input element, output ready);
endinterface

### rtl/imk_step.sv
// imk_step: next-state and result logic for one tick of the keyer
// element start, paddle memory and mark/space timing against the dit length
// depends on imk_pkg
module imk_step #(
   parameter int TIMER_BITS = imk_pkg::TIMER_BITS_DEFAULT
) (
   input  logic [imk_pkg::PH_W-1:0]  phase,
   input  logic [TIMER_BITS-1:0]     tick_count,
   input  logic                      opposite_latched,
   input  logic                      dah_paddle,
   input  logic                      dit_paddle,
   input  logic [imk_pkg::DIT_W-1:0] dit_ticks,
   output logic [imk_pkg::PH_W-1:0]  phase_next,
   output logic [TIMER_BITS-1:0]     tick_count_next,
   output logic                      opposite_latched_next,
   output imk_pkg::rsp_type          result
);

   localparam int CMP_W = (TIMER_BITS > imk_pkg::MARK3_W) ? TIMER_BITS : imk_pkg::MARK3_W;
   localparam logic [CMP_W-1:0] TIMER_MAX = CMP_W'((64'd1 << TIMER_BITS) - 64'd1);

   logic [imk_pkg::DIT_W-1:0]   unit;
   logic [imk_pkg::MARK3_W-1:0] mark3;
   logic [TIMER_BITS-1:0]       space_len;
   logic [TIMER_BITS-1:0]       dah_len;

   assign unit  = (dit_ticks == '0) ? imk_pkg::DIT_W'(1) : dit_ticks;
   assign mark3 = imk_pkg::MARK3_W'(unit) + imk_pkg::MARK3_W'({unit, 1'b0});

   // saturate lengths that do not fit the timer
   assign space_len = (CMP_W'(unit) > TIMER_MAX) ? TIMER_MAX[TIMER_BITS-1:0]
                                                 : TIMER_BITS'(CMP_W'(unit));
   assign dah_len   = (CMP_W'(mark3) > TIMER_MAX) ? TIMER_MAX[TIMER_BITS-1:0]
                                                  : TIMER_BITS'(CMP_W'(mark3));

   always_comb begin
      logic [imk_pkg::PH_W-1:0] ph;
      logic                     started;
      logic [TIMER_BITS-1:0]    cnt;
      logic [TIMER_BITS-1:0]    cnt_inc;
      logic                     lat;
      logic                     is_dah;
      logic                     is_mark;
      logic [TIMER_BITS-1:0]    len;

      ph      = (phase > imk_pkg::PH_DAH_SPACE) ? imk_pkg::PH_IDLE : phase;
      started = 1'b1;
      cnt     = tick_count;
      lat     = opposite_latched;

      phase_next            = ph;
      tick_count_next       = tick_count;
      opposite_latched_next = opposite_latched;
      result.tone           = 1'b0;
      result.element        = imk_pkg::ELEM_IDLE;

      if (ph == imk_pkg::PH_IDLE) begin
         if (dah_paddle) begin
            ph = imk_pkg::PH_DAH_MARK;
         end else if (dit_paddle) begin
            ph = imk_pkg::PH_DIT_MARK;
         end else begin
            started = 1'b0;
         end
         cnt = '0;
         lat = 1'b0;
      end

      is_dah  = (ph == imk_pkg::PH_DAH_MARK) || (ph == imk_pkg::PH_DAH_SPACE);
      is_mark = (ph == imk_pkg::PH_DAH_MARK) || (ph == imk_pkg::PH_DIT_MARK);
      len     = (is_mark && is_dah) ? dah_len : space_len;
      cnt_inc = cnt + TIMER_BITS'(1);

      if (started) begin
         // paddle memory: opposite paddle seen on any tick of the element
         if (is_dah ? dit_paddle : dah_paddle) begin
            lat = 1'b1;
         end
         result.tone    = is_mark;
         result.element = is_dah ? imk_pkg::ELEM_DAH : imk_pkg::ELEM_DIT;
         if (cnt_inc >= len) begin
            tick_count_next = '0;
            if (is_mark) begin
               phase_next            = is_dah ? imk_pkg::PH_DAH_SPACE : imk_pkg::PH_DIT_SPACE;
               opposite_latched_next = lat;
            end else begin
               if (lat) begin
                  phase_next = is_dah ? imk_pkg::PH_DIT_MARK : imk_pkg::PH_DAH_MARK;
               end else begin
                  phase_next = imk_pkg::PH_IDLE;
               end
               opposite_latched_next = 1'b0;
            end
         end else begin
            phase_next            = ph;
            tick_count_next       = cnt_inc;
            opposite_latched_next = lat;
         end
      end else begin
         phase_next = imk_pkg::PH_IDLE;
      end
   end

endmodule

### rtl/iambic_morse_keyer_unit.sv
// iambic_morse_keyer_unit: top level of the iambic keyer with paddle memory
// keyer state registers, dit length register and a two-entry result buffer
// depends on imk_pkg, imk_if (imk_req_if, imk_rsp_if) and imk_step
//
// usage:
//  req carries one transaction per millisecond tick with the dah and dit paddle
//  levels; rsp returns one transaction per tick with the tone level and the
//  element in progress (idle, dit or dah).
//  csr_wr_en with csr_wr_data loads the dit length in ticks (1200 / wpm);
//  write it only while no tick is in flight.
//  throughput: one tick per cycle while req_ready is high; the per-tick work
//  is one state update and one counter compare in imk_step between the state
//  and result registers, and each result is registered before it reaches rsp.
//  when rsp stalls, results queue in the output register and a skid register;
//  req_ready drops only once both are full and returns as rsp drains.
//  reset (synchronous, active high) empties the result buffer, puts the keyer
//  in idle with the timer and paddle memory cleared, and sets the dit length
//  to 60 ticks.
module iambic_morse_keyer_unit #(
   parameter int TIMER_BITS = imk_pkg::TIMER_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   imk_req_if.sink                   req,
   imk_rsp_if.source                 rsp,
   input  logic                      csr_wr_en,
   input  logic [imk_pkg::DIT_W-1:0] csr_wr_data
);

   logic [imk_pkg::DIT_W-1:0] dit_ticks_ff;
   logic [imk_pkg::PH_W-1:0]  phase_ff;
   logic [imk_pkg::PH_W-1:0]  phase_in;
   logic [TIMER_BITS-1:0]     tick_count_ff;
   logic [TIMER_BITS-1:0]     tick_count_in;
   logic                      latched_ff;
   logic                      latched_in;
   imk_pkg::rsp_type          result;

   logic             out_valid_ff;
   imk_pkg::rsp_type out_data_ff;
   logic             skid_valid_ff;
   imk_pkg::rsp_type skid_data_ff;

   logic accept;
   logic out_take;

   assign req.ready = !skid_valid_ff;
   assign accept    = req.valid && !skid_valid_ff;
   assign out_take  = out_valid_ff && rsp.ready;

   imk_step #(
      .TIMER_BITS (TIMER_BITS)
   ) u_step (
      .phase                 (phase_ff),
      .tick_count            (tick_count_ff),
      .opposite_latched      (latched_ff),
      .dah_paddle            (req.dah_paddle),
      .dit_paddle            (req.dit_paddle),
      .dit_ticks             (dit_ticks_ff),
      .phase_next            (phase_in),
      .tick_count_next       (tick_count_in),
      .opposite_latched_next (latched_in),
      .result                (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         dit_ticks_ff <= imk_pkg::DIT_TICKS_RESET;
      end else if (csr_wr_en) begin
         dit_ticks_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= imk_pkg::PH_IDLE;
         tick_count_ff <= '0;
         latched_ff    <= 1'b0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         tick_count_ff <= tick_count_in;
         latched_ff    <= latched_in;
      end
   end

   // result buffer: output register backed by one skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            if (!out_valid_ff || out_take) begin
               out_valid_ff <= 1'b1;
            end else begin
               skid_valid_ff <= 1'b1;
            end
         end else if (out_take) begin
            if (skid_valid_ff) begin
               skid_valid_ff <= 1'b0;
            end else begin
               out_valid_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         if (!out_valid_ff || out_take) begin
            out_data_ff <= result;
         end else begin
            skid_data_ff <= result;
         end
      end else if (out_take && skid_valid_ff) begin
         out_data_ff <= skid_data_ff;
      end
   end

   assign rsp.valid   = out_valid_ff;
   assign rsp.tone    = out_data_ff.tone;
   assign rsp.element = out_data_ff.element;

endmodule
